/* hdl/dcf_pkg.sv */
// dcf_pkg: shared types, constants and frame building functions for the
// time code generator; no dependencies
package dcf_pkg;

  localparam int unsigned FRAME_BITS  = 59;
  localparam int unsigned WARN_W      = 14;
  localparam int unsigned SECOND_W    = 6;
  localparam logic [WARN_W-1:0]   WARN_RESET  = 14'd511;
  localparam logic [SECOND_W-1:0] LAST_SECOND = 6'd59;
  localparam logic [6:0]          CENTURY     = 7'd100;

  // one tick transaction
  typedef struct packed {
    logic       start_of_minute;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
    logic [3:0] month;
    logic [6:0] year_in_century;
    logic       summer_time;
  } dcf_tick_t;

  // one code transaction
  typedef struct packed {
    logic                carrier_reduced;
    logic [SECOND_W-1:0] second_index;
    logic                bit_value;
    logic                running;
  } dcf_code_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } dcf_bcd_t;

  typedef logic [FRAME_BITS-1:0] dcf_frame_t;

  // split 0..127 into tens and units, reciprocal multiply by 205/2048
  function automatic dcf_bcd_t split_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [6:0]  tens_x10;
    dcf_bcd_t    r;
    prod     = 15'(v) * 15'd205;
    r.tens   = prod[14:11];
    tens_x10 = 7'(r.tens) * 7'd10;
    r.units  = 4'(v - tens_x10);
    return r;
  endfunction

  function automatic dcf_frame_t build_frame(input dcf_tick_t t,
                                             input logic [WARN_W-1:0] warn);
    dcf_frame_t f;
    dcf_bcd_t   mi;
    dcf_bcd_t   hr;
    dcf_bcd_t   dy;
    dcf_bcd_t   mo;
    dcf_bcd_t   yr;
    logic [6:0] yr_mod;
    logic [2:0] wd;
    yr_mod   = (t.year_in_century >= CENTURY) ? t.year_in_century - CENTURY
                                              : t.year_in_century;
    mi       = split_bcd(7'(t.minute));
    hr       = split_bcd(7'(t.hour));
    dy       = split_bcd(7'(t.day_of_month));
    mo       = split_bcd(7'(t.month));
    yr       = split_bcd(yr_mod);
    wd       = (t.weekday == 3'd0) ? 3'd7 : t.weekday;
    f        = '0;
    f[14:1]  = warn;
    f[17]    = t.summer_time;
    f[18]    = ~t.summer_time;
    f[20]    = 1'b1;
    f[24:21] = mi.units;
    f[27:25] = mi.tens[2:0];
    f[28]    = ^f[27:21];
    f[32:29] = hr.units;
    f[34:33] = hr.tens[1:0];
    f[35]    = ^f[34:29];
    f[39:36] = dy.units;
    f[41:40] = dy.tens[1:0];
    f[44:42] = wd;
    f[48:45] = mo.units;
    f[49]    = mo.tens[0];
    f[53:50] = yr.units;
    f[57:54] = yr.tens;
    f[58]    = ^f[57:36];
    return f;
  endfunction

endpackage

/* hdl/dcf_stream_if.sv */
// dcf_stream_if: valid/ready channel with a typed payload
// payload types come from dcf_pkg
interface dcf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/dcf77_time_code_generator.sv */
// dcf77_time_code_generator: top level of the minute frame generator
// depends on dcf_pkg and dcf_stream_if
//
// Takes one tick transaction per cycle on tick_i and returns one code transaction
// on code_o for each, in the cycle after the tick is taken. A tick goes through
// one combinational pass (counter update, frame build, bit select) into the
// output register; tick_i stays ready as long as the output register is empty
// or is being drained in the same cycle, so the sustained rate is one tick per
// cycle and only the sink's ready on code_o can slow it. A tick with
// start_of_minute set starts second 0 and latches a fresh 59-bit frame from the
// time fields of that tick; every later wrap from second 59 to second 0 latches
// again. Until the first start of minute the counters hold and the block reports
// second 59, no carrier drop and running low. The user must write warning_bits
// through cfg_we_i/cfg_wdata_i only while no tick is in flight; it is unchecked.
module dcf77_time_code_generator #(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dcf_pkg::WARN_W-1:0] cfg_wdata_i,
  dcf_stream_if.sink                tick_i,
  dcf_stream_if.source              code_o
);
  import dcf_pkg::*;

  localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND);
  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

  // configuration
  logic [WARN_W-1:0]   warn_q;

  // minute state
  dcf_frame_t          frame_q, frame_d;
  logic [SECOND_W-1:0] second_q, second_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic                synced_q, synced_d;

  // output register
  logic                out_valid_q;
  dcf_code_t           out_q, out_d;

  dcf_tick_t           tick_in;
  dcf_frame_t          new_frame;
  logic                accept;
  logic                sel_bit;

  assign tick_in   = tick_i.payload;
  assign new_frame = build_frame(tick_in, warn_q);

  // a tick is taken when the output register is free or drains this cycle
  assign tick_i.ready = ~out_valid_q | code_o.ready;
  assign accept       = tick_i.valid & tick_i.ready;

  // counter update for one tick
  always_comb begin
    frame_d  = frame_q;
    second_d = second_q;
    tick_d   = tick_q;
    synced_d = synced_q;
    if (tick_in.start_of_minute) begin
      // forced restart at the first tick of second 0
      synced_d = 1'b1;
      second_d = '0;
      tick_d   = '0;
      frame_d  = new_frame;
    end else if (synced_q) begin
      if (tick_q == TICK_LAST) begin
        tick_d = '0;
        if (second_q == LAST_SECOND) begin
          // minute wrap: latch the next frame
          second_d = '0;
          frame_d  = new_frame;
        end else begin
          second_d = second_q + 1'b1;
        end
      end else begin
        tick_d = tick_q + 1'b1;
      end
    end
  end

  // carrier drop: first tick for a zero bit, first two ticks for a one bit,
  // never in second 59 or before sync
  always_comb begin
    sel_bit = 1'b0;
    if (synced_d && (second_d != LAST_SECOND)) begin
      sel_bit = frame_d[second_d];
    end
    out_d.bit_value       = sel_bit;
    out_d.carrier_reduced = synced_d && (second_d != LAST_SECOND) &&
                            ((tick_d == '0) || (sel_bit && (tick_d == TICK_W'(1))));
    out_d.second_index    = second_d;
    out_d.running         = synced_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q      <= WARN_RESET;
      frame_q     <= '0;
      second_q    <= LAST_SECOND;
      tick_q      <= '0;
      synced_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        warn_q <= cfg_wdata_i;
      end
      if (accept) begin
        frame_q     <= frame_d;
        second_q    <= second_d;
        tick_q      <= tick_d;
        synced_q    <= synced_d;
        out_valid_q <= 1'b1;
      end else if (code_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, loaded with each taken tick
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign code_o.valid   = out_valid_q;
  assign code_o.payload = out_q;

endmodule

/* hdl/dcf_checker.sv */
// dcf_checker: port-level checks for dcf77_time_code_generator, bound in below
// depends on dcf_pkg
module dcf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               tick_valid_i,
  input logic               tick_ready_i,
  input logic               code_valid_i,
  input logic               code_ready_i,
  input dcf_pkg::dcf_code_t code_i
);
  import dcf_pkg::*;

  // each taken tick shows a code transaction on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_valid_i && tick_ready_i |=> code_valid_i)
    else $error("no code after taken tick");

  // not running means idle carrier parked on second 59
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_valid_i && !code_i.running |->
      code_i.second_index == LAST_SECOND && !code_i.carrier_reduced && !code_i.bit_value)
    else $error("activity before sync");

  // second 59 never drops the carrier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_valid_i && code_i.second_index == LAST_SECOND |->
      !code_i.carrier_reduced && !code_i.bit_value)
    else $error("drop in second 59");

  // stalled code transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_valid_i && !code_ready_i |=> code_valid_i && $stable(code_i))
    else $error("stalled code changed");

endmodule

bind dcf77_time_code_generator dcf_checker u_dcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tick_valid_i (tick_i.valid),
  .tick_ready_i (tick_i.ready),
  .code_valid_i (code_o.valid),
  .code_ready_i (code_o.ready),
  .code_i       (code_o.payload)
);
